### sv/ubxrb_pkg.sv
// Shared constants, codes, result type and pointer helper for the UBX frame ring buffer.
`default_nettype none

package ubxrb_pkg;

    localparam int FIFO_DEPTH     = 1024;
    localparam int MAX_PAYLOAD    = 56;
    localparam int FRAME_OVERHEAD = 8;

    localparam int ADDR_W = $clog2(FIFO_DEPTH);
    localparam int FILL_W = ADDR_W + 1;
    localparam int LEN_W  = 7;
    localparam int OVF_W  = 32;

    localparam logic [7:0] SYNC_A     = 8'hB5;
    localparam logic [7:0] SYNC_B     = 8'h62;
    localparam int         LEN_OFFSET = 4;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_EXTRACT = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       frame_byte;
        logic             last;
        logic [LEN_W-1:0] frame_length;
        logic [OVF_W-1:0] overflow_total;
    } ubxrb_result_t;

    // Ring pointer plus a small offset, wrapped at FIFO_DEPTH (offset <= FIFO_DEPTH).
    function automatic logic [ADDR_W-1:0] ptr_add(input logic [ADDR_W-1:0] ptr,
                                                  input logic [LEN_W-1:0]  off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, ptr} + (ADDR_W+1)'(off);
        if (sum >= (ADDR_W+1)'(FIFO_DEPTH))
        begin
            sum = sum - (ADDR_W+1)'(FIFO_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/ubx_frame_ring_buffer_top.sv
// Top level of the UBX frame ring buffer: sequencer with byte store plus output register.
//
// Input channel (in_valid / in_ready): one transaction carries opcode, data_byte and
// end_of_burst. Opcode push stores a byte (dropping the oldest one when the 1024-byte
// store is full), extract asks for the next UBX frame, clear empties the buffer.
// Output channel (out_valid / out_ready): one transaction per result item; kind tells an
// overflow notice, a frame byte or a no-frame answer, last marks the end of a run.
// Push and clear go straight back to idle, so pushes stream at one per cycle; a push that
// ends an overflowed burst holds the input while its notice is handed on.
// A result passes through the output register before it shows on the output.
// Extract is bound by the single read port of the byte store: each header probe is a
// read followed by a check. The probes check sync A, sync B and the two length bytes
// in turn; a byte that fails is dropped and probing starts again at sync A. Copy-out
// then reads and hands on each frame byte in turn (up to 64 bytes).
// A stalled receiver holds the output register and then the sequencer; nothing is lost.
// The input stays ready while a finished result still waits in the output register.
// Reset clears pointers, fill count, overflow counter and burst flag at once; the store
// contents are not cleared and need no clearing pass. Clear keeps the overflow counter.
`default_nettype none

module ubx_frame_ring_buffer_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                opcode,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      end_of_burst,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     kind,
    output logic [7:0]                     frame_byte,
    output logic                           last,
    output logic [ubxrb_pkg::LEN_W-1:0]    frame_length,
    output logic [ubxrb_pkg::OVF_W-1:0]    overflow_total
);
    import ubxrb_pkg::*;

    logic          res_valid;
    logic          res_ready;
    ubxrb_result_t res;

    // store, pointers and resync / copy-out sequencing
    ubxrb_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .data_byte    (data_byte),
        .end_of_burst (end_of_burst),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // decouples the result channel from the sequencer
    ubxrb_out_reg u_out_reg (
        .clk            (clk),
        .rst_n          (rst_n),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .frame_byte     (frame_byte),
        .last           (last),
        .frame_length   (frame_length),
        .overflow_total (overflow_total)
    );

endmodule

`default_nettype wire

### sv/ubxrb_engine.sv
// Byte store, ring pointers and the push / resync / copy-out sequencer.
`default_nettype none

module ubxrb_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              opcode,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    end_of_burst,
    output logic                         res_valid,
    input  wire logic                    res_ready,
    output ubxrb_pkg::ubxrb_result_t     res
);
    import ubxrb_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_NOTE     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_EVAL     = 3'd3;
    localparam logic [2:0] ST_COPY_RD  = 3'd4;
    localparam logic [2:0] ST_COPY_OUT = 3'd5;
    localparam logic [2:0] ST_NOFRM    = 3'd6;

    localparam logic [1:0] PH_SYNC_A = 2'd0;
    localparam logic [1:0] PH_SYNC_B = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_LEN_HI = 2'd3;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;
    logic              burst_reg, burst_next;
    logic [7:0]        len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]  flen_reg, flen_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic [7:0]        mem [FIFO_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic              in_fire;
    logic              push_full;
    logic              copy_last;
    logic [LEN_W-1:0]  hdr_off;
    logic [LEN_W-1:0]  flen_calc;

    assign in_fire   = in_valid && in_ready;
    assign push_full = (fill_reg == FILL_W'(FIFO_DEPTH));
    assign copy_last = (idx_reg == (flen_reg - LEN_W'(1)));
    assign flen_calc = LEN_W'(FRAME_OVERHEAD) + LEN_W'(len_lo_reg);

    always_comb
    begin
        unique case (phase_reg)
            PH_SYNC_A: hdr_off = LEN_W'(0);
            PH_SYNC_B: hdr_off = LEN_W'(1);
            PH_LEN_LO: hdr_off = LEN_W'(LEN_OFFSET);
            PH_LEN_HI: hdr_off = LEN_W'(LEN_OFFSET + 1);
            default:   hdr_off = LEN_W'(0);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        burst_next  = burst_reg;
        len_lo_next = len_lo_reg;
        flen_next   = flen_reg;
        idx_next    = idx_reg;
        in_ready    = (state_reg == ST_IDLE);
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = rp_reg;
        res_valid   = 1'b0;
        res.kind           = KIND_NOTE;
        res.frame_byte     = 8'd0;
        res.last           = 1'b1;
        res.frame_length   = '0;
        res.overflow_total = ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (opcode)
                        OP_PUSH:
                        begin
                            wr_en   = 1'b1;
                            wp_next = ptr_add(wp_reg, LEN_W'(1));
                            if (push_full)
                            begin
                                // full: oldest byte goes, fill stays
                                rp_next  = ptr_add(rp_reg, LEN_W'(1));
                                ovf_next = ovf_reg + OVF_W'(1);
                            end
                            else
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                            if (end_of_burst)
                            begin
                                burst_next = 1'b0;
                                if (burst_reg || push_full)
                                begin
                                    state_next = ST_NOTE;
                                end
                            end
                            else
                            begin
                                burst_next = burst_reg || push_full;
                            end
                        end
                        OP_EXTRACT:
                        begin
                            phase_next = PH_SYNC_A;
                            state_next = ST_SCAN;
                        end
                        OP_CLEAR:
                        begin
                            wp_next   = '0;
                            rp_next   = '0;
                            fill_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_NOTE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (fill_reg < FILL_W'(FRAME_OVERHEAD))
                begin
                    state_next = ST_NOFRM;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_add(rp_reg, hdr_off);
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = ST_SCAN;
                unique case (phase_reg)
                    PH_SYNC_A:
                    begin
                        if (rd_data_reg != SYNC_A)
                        begin
                            rp_next   = ptr_add(rp_reg, LEN_W'(1));
                            fill_next = fill_reg - FILL_W'(1);
                        end
                        else
                        begin
                            phase_next = PH_SYNC_B;
                        end
                    end
                    PH_SYNC_B:
                    begin
                        if (rd_data_reg != SYNC_B)
                        begin
                            rp_next    = ptr_add(rp_reg, LEN_W'(1));
                            fill_next  = fill_reg - FILL_W'(1);
                            phase_next = PH_SYNC_A;
                        end
                        else
                        begin
                            phase_next = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        len_lo_next = rd_data_reg;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        phase_next = PH_SYNC_A;
                        if ((rd_data_reg != 8'd0) || (len_lo_reg > 8'(MAX_PAYLOAD)))
                        begin
                            // bogus length: treat sync as noise
                            rp_next   = ptr_add(rp_reg, LEN_W'(1));
                            fill_next = fill_reg - FILL_W'(1);
                        end
                        else if (fill_reg < FILL_W'(flen_calc))
                        begin
                            state_next = ST_NOFRM;
                        end
                        else
                        begin
                            flen_next  = flen_calc;
                            idx_next   = '0;
                            state_next = ST_COPY_RD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_COPY_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = ptr_add(rp_reg, idx_reg);
                state_next = ST_COPY_OUT;
            end
            ST_COPY_OUT:
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_FRAME;
                res.frame_byte   = rd_data_reg;
                res.last         = copy_last;
                res.frame_length = flen_reg;
                if (res_ready)
                begin
                    if (copy_last)
                    begin
                        rp_next    = ptr_add(rp_reg, flen_reg);
                        fill_next  = fill_reg - FILL_W'(flen_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_NOFRM:
            begin
                res_valid = 1'b1;
                res.kind  = KIND_NONE;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SYNC_A;
            wp_reg    <= '0;
            rp_reg    <= '0;
            fill_reg  <= '0;
            ovf_reg   <= '0;
            burst_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            burst_reg <= burst_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_lo_reg <= len_lo_next;
        flen_reg   <= flen_next;
    end

    // byte store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // write pointer must always sit fill bytes past the read pointer
    logic [FILL_W-1:0] chk_sum;
    logic [FILL_W-1:0] chk_wrap;
    assign chk_sum  = FILL_W'(rp_reg) + fill_reg;
    assign chk_wrap = (chk_sum >= FILL_W'(FIFO_DEPTH)) ? (chk_sum - FILL_W'(FIFO_DEPTH))
                                                       : chk_sum;

    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        chk_wrap[ADDR_W-1:0] == wp_reg)
        else $error("write pointer out of step with read pointer and fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(FIFO_DEPTH))
        else $error("fill count above depth");

    a_push_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == OP_PUSH && !push_full)
        |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("push did not grow fill count");

    a_frame_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_OUT && res_ready && copy_last)
        |=> (fill_reg == $past(fill_reg) - FILL_W'($past(flen_reg))))
        else $error("frame not removed after copy-out");

    a_ovf_only_push: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && opcode == OP_PUSH) |=> $stable(ovf_reg))
        else $error("overflow counter moved without a push");

endmodule

`default_nettype wire

### sv/ubxrb_out_reg.sv
// Output register stage between the sequencer and the result channel.
`default_nettype none

module ubxrb_out_reg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        res_valid,
    output logic                             res_ready,
    input  wire ubxrb_pkg::ubxrb_result_t    res,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [1:0]                       kind,
    output logic [7:0]                       frame_byte,
    output logic                             last,
    output logic [ubxrb_pkg::LEN_W-1:0]      frame_length,
    output logic [ubxrb_pkg::OVF_W-1:0]      overflow_total
);
    import ubxrb_pkg::*;

    logic          valid_reg, valid_next;
    ubxrb_result_t data_reg;
    logic          load;

    assign res_ready  = !valid_reg || out_ready;
    assign load       = res_valid && res_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = data_reg.kind;
    assign frame_byte     = data_reg.frame_byte;
    assign last           = data_reg.last;
    assign frame_length   = data_reg.frame_length;
    assign overflow_total = data_reg.overflow_total;

endmodule

`default_nettype wire
